[hw/rtl/sfc_pkg.sv]
// Shared types, codes and defaults for the serial frame checker
package sfc_pkg;

   // Default frame layout
   localparam int BUF_DEPTH_DEF      = 128;
   localparam int HDR_FIRST_POS_DEF  = 0;
   localparam int HDR_SECOND_POS_DEF = 1;
   localparam int LEN_FIELD_POS_DEF  = 2;
   localparam int DATA_START_POS_DEF = 3;

   // Depth of the queues on either side of the engine (power of two)
   localparam int QUEUE_DEPTH = 2;

   // Width that holds any count or position compare without wrap (up to 511)
   localparam int CNT_EXT_W = 9;

   // Item kinds
   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_POLL = 1'b1;

   // Register indexes
   localparam logic CSR_START_FIRST  = 1'b0;
   localparam logic CSR_START_SECOND = 1'b1;

   // Status codes
   localparam logic [2:0] ST_EMPTY     = 3'd0;
   localparam logic [2:0] ST_RECEIVING = 3'd1;
   localparam logic [2:0] ST_OK        = 3'd2;
   localparam logic [2:0] ST_HDR_ERR   = 3'd3;
   localparam logic [2:0] ST_LEN_ERR   = 3'd4;
   localparam logic [2:0] ST_CK_ERR    = 3'd5;

   // Input item
   typedef struct packed {
      logic       kind;
      logic [7:0] data;
   } req_item_type;

   // Result item
   typedef struct packed {
      logic [2:0] status;
      logic [6:0] frame_length;
   } rsp_item_type;

endpackage

[hw/rtl/sfc_fifo.sv]
// Small register queue used in front of and behind the frame engine
module sfc_fifo #(
   parameter int WIDTH = 9,
   parameter int DEPTH = sfc_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rdata
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push, do_pop;

   assign full    = (fill_ff == CNT_W'(DEPTH));
   assign empty   = (fill_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slot_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = do_push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = CNT_W'(fill_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         fill_in = CNT_W'(fill_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Payload slots, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

[hw/rtl/sfc_engine.sv]
// Frame engine: tracks received bytes and answers poll items with a status
module sfc_engine #(
   parameter int BUF_DEPTH      = sfc_pkg::BUF_DEPTH_DEF,
   parameter int HDR_FIRST_POS  = sfc_pkg::HDR_FIRST_POS_DEF,
   parameter int HDR_SECOND_POS = sfc_pkg::HDR_SECOND_POS_DEF,
   parameter int LEN_FIELD_POS  = sfc_pkg::LEN_FIELD_POS_DEF,
   parameter int DATA_START_POS = sfc_pkg::DATA_START_POS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [7:0]            csr_wdata,
   input  logic                  in_valid,
   input  sfc_pkg::req_item_type in_item,
   output logic                  in_take,
   input  logic                  out_full,
   output logic                  out_push,
   output sfc_pkg::rsp_item_type out_item
);

   localparam int CNT_W = $clog2(BUF_DEPTH + 1);
   localparam int EW    = sfc_pkg::CNT_EXT_W;

   // Start byte registers
   logic [7:0] start_first_ff, start_second_ff;

   // Frame state
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] last_ff, last_in;
   logic [7:0]       hdr1_ff, hdr1_in;
   logic [7:0]       hdr2_ff, hdr2_in;
   logic [7:0]       len_ff, len_in;
   logic [7:0]       newest_ff, newest_in;
   logic [7:0]       older_ff, older_in;
   logic [15:0]      sum_ff, sum_in;

   logic          is_poll, do_byte, do_poll, frame_done;
   logic [EW-1:0] n_ext, len_plus2;
   logic [2:0]    check_status;
   logic [2:0]    status;

   assign is_poll  = (in_item.kind == sfc_pkg::REQ_POLL);
   assign in_take  = in_valid && (!is_poll || !out_full);
   assign do_byte  = in_take && !is_poll;
   assign do_poll  = in_take && is_poll;
   assign out_push = do_poll;

   assign frame_done = do_poll && (cnt_ff != '0) && (cnt_ff == last_ff);

   // Frame check: header, then length, then checksum
   assign n_ext     = EW'(cnt_ff);
   assign len_plus2 = EW'(len_ff) + EW'(2);
   always_comb begin
      if (n_ext <= EW'(HDR_FIRST_POS) || n_ext <= EW'(HDR_SECOND_POS) ||
          hdr1_ff != start_first_ff || hdr2_ff != start_second_ff) begin
         check_status = sfc_pkg::ST_HDR_ERR;
      end else if (n_ext >= EW'(BUF_DEPTH) || n_ext <= EW'(LEN_FIELD_POS) ||
                   len_plus2 != n_ext || n_ext <= EW'(DATA_START_POS)) begin
         check_status = sfc_pkg::ST_LEN_ERR;
      end else if ({newest_ff, older_ff} != ~sum_ff) begin
         check_status = sfc_pkg::ST_CK_ERR;
      end else begin
         check_status = sfc_pkg::ST_OK;
      end
   end

   // Poll answer
   always_comb begin
      if (cnt_ff == '0) begin
         status = sfc_pkg::ST_EMPTY;
      end else if (cnt_ff != last_ff) begin
         status = sfc_pkg::ST_RECEIVING;
      end else begin
         status = check_status;
      end
      out_item.status       = status;
      out_item.frame_length = (status == sfc_pkg::ST_OK) ? n_ext[6:0] : 7'd0;
   end

   // Next frame state
   always_comb begin
      cnt_in    = cnt_ff;
      last_in   = last_ff;
      hdr1_in   = hdr1_ff;
      hdr2_in   = hdr2_ff;
      len_in    = len_ff;
      newest_in = newest_ff;
      older_in  = older_ff;
      sum_in    = sum_ff;
      if (do_byte && cnt_ff < CNT_W'(BUF_DEPTH)) begin
         if (cnt_ff == CNT_W'(HDR_FIRST_POS)) begin
            hdr1_in = in_item.data;
         end
         if (cnt_ff == CNT_W'(HDR_SECOND_POS)) begin
            hdr2_in = in_item.data;
         end
         if (cnt_ff == CNT_W'(LEN_FIELD_POS)) begin
            len_in = in_item.data;
         end
         if (cnt_ff >= CNT_W'(2)) begin
            sum_in = sum_ff + 16'(older_ff);
         end
         older_in  = newest_ff;
         newest_in = in_item.data;
         cnt_in    = CNT_W'(cnt_ff + 1'b1);
      end else if (frame_done) begin
         cnt_in    = '0;
         last_in   = '0;
         hdr1_in   = '0;
         hdr2_in   = '0;
         len_in    = '0;
         newest_in = '0;
         older_in  = '0;
         sum_in    = '0;
      end else if (do_poll && cnt_ff != '0) begin
         last_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         last_ff   <= '0;
         hdr1_ff   <= '0;
         hdr2_ff   <= '0;
         len_ff    <= '0;
         newest_ff <= '0;
         older_ff  <= '0;
         sum_ff    <= '0;
      end else begin
         cnt_ff    <= cnt_in;
         last_ff   <= last_in;
         hdr1_ff   <= hdr1_in;
         hdr2_ff   <= hdr2_in;
         len_ff    <= len_in;
         newest_ff <= newest_in;
         older_ff  <= older_in;
         sum_ff    <= sum_in;
      end
   end

   // Start byte registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_first_ff  <= '0;
         start_second_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            sfc_pkg::CSR_START_FIRST:  start_first_ff  <= csr_wdata;
            sfc_pkg::CSR_START_SECOND: start_second_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Count never passes the store depth
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(BUF_DEPTH))
      else $error("byte count above store depth");

   // Count seen at last poll never runs ahead of the count
   a_last_bound: assert property (@(posedge clock) disable iff (reset)
      last_ff <= cnt_ff)
      else $error("last poll count ahead of byte count");

   // A checked frame leaves an empty store
   a_clear: assert property (@(posedge clock) disable iff (reset)
      frame_done |=> (cnt_ff == '0 && sum_ff == '0))
      else $error("store not cleared after frame check");

   // Length is reported only with a good frame
   a_len_ok: assert property (@(posedge clock) disable iff (reset)
      (out_push && out_item.status != sfc_pkg::ST_OK) |-> out_item.frame_length == 7'd0)
      else $error("frame length on a non-ok status");

   // Bytes never produce a result
   a_byte_quiet: assert property (@(posedge clock) disable iff (reset)
      do_byte |-> !out_push)
      else $error("result pushed for a byte item");

endmodule

[hw/rtl/serial_frame_checker.sv]
// Serial frame checker top level: input queue, frame engine, result queue
// A poll item's result is pushed into the result queue when the engine takes the poll.
// The engine takes one item per cycle from the input queue unless a poll stalls.
// A poll stalls only while the 2-entry result queue is full; items behind it wait in order.
// Reset (synchronous, active high) empties both queues, clears the frame state
// and the start byte registers; no clearing pass follows.
module serial_frame_checker #(
   parameter int BUF_DEPTH      = sfc_pkg::BUF_DEPTH_DEF,
   parameter int HDR_FIRST_POS  = sfc_pkg::HDR_FIRST_POS_DEF,
   parameter int HDR_SECOND_POS = sfc_pkg::HDR_SECOND_POS_DEF,
   parameter int LEN_FIELD_POS  = sfc_pkg::LEN_FIELD_POS_DEF,
   parameter int DATA_START_POS = sfc_pkg::DATA_START_POS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic       req_type,
   input  logic [7:0] req_rx_byte,
   output logic       empty,
   input  logic       pop,
   output logic [2:0] rsp_status,
   output logic [6:0] rsp_frame_length,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   localparam int REQ_W = $bits(sfc_pkg::req_item_type);
   localparam int RSP_W = $bits(sfc_pkg::rsp_item_type);

   sfc_pkg::req_item_type req_in, req_head;
   sfc_pkg::rsp_item_type rsp_new, rsp_head;
   logic [REQ_W-1:0]      req_head_bits;
   logic [RSP_W-1:0]      rsp_head_bits;
   logic                  req_empty, req_take;
   logic                  rsp_full, rsp_push;

   // Pack the incoming item
   assign req_in.kind = req_type;
   assign req_in.data = req_rx_byte;

   // Front: input queue
   sfc_fifo #(
      .WIDTH(REQ_W),
      .DEPTH(sfc_pkg::QUEUE_DEPTH)
   ) u_req_queue (
      .clock(clock),
      .reset(reset),
      .push (push),
      .full (full),
      .wdata(req_in),
      .pop  (req_take),
      .empty(req_empty),
      .rdata(req_head_bits)
   );

   assign req_head = sfc_pkg::req_item_type'(req_head_bits);

   // Back: frame engine
   sfc_engine #(
      .BUF_DEPTH     (BUF_DEPTH),
      .HDR_FIRST_POS (HDR_FIRST_POS),
      .HDR_SECOND_POS(HDR_SECOND_POS),
      .LEN_FIELD_POS (LEN_FIELD_POS),
      .DATA_START_POS(DATA_START_POS)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .in_valid (!req_empty),
      .in_item  (req_head),
      .in_take  (req_take),
      .out_full (rsp_full),
      .out_push (rsp_push),
      .out_item (rsp_new)
   );

   // Result queue
   sfc_fifo #(
      .WIDTH(RSP_W),
      .DEPTH(sfc_pkg::QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock(clock),
      .reset(reset),
      .push (rsp_push),
      .full (rsp_full),
      .wdata(rsp_new),
      .pop  (pop),
      .empty(empty),
      .rdata(rsp_head_bits)
   );

   assign rsp_head         = sfc_pkg::rsp_item_type'(rsp_head_bits);
   assign rsp_status       = rsp_head.status;
   assign rsp_frame_length = rsp_head.frame_length;

endmodule

[tb/serial_frame_checker_tb.sv]
// Self-checking testbench for serial_frame_checker: frame traffic, polls and status checks
module serial_frame_checker_tb;

   localparam int BUF_DEPTH      = sfc_pkg::BUF_DEPTH_DEF;
   localparam int HDR_FIRST_POS  = sfc_pkg::HDR_FIRST_POS_DEF;
   localparam int HDR_SECOND_POS = sfc_pkg::HDR_SECOND_POS_DEF;
   localparam int LEN_FIELD_POS  = sfc_pkg::LEN_FIELD_POS_DEF;
   localparam int DATA_START_POS = sfc_pkg::DATA_START_POS_DEF;
   localparam int CK_BYTES       = 2;          // checksum bytes closing a frame
   localparam int PHASE_ITEMS    = 100;        // random items per register setting
   localparam int DRAIN_TAIL     = 8;          // cycles after the last result
   localparam int CYCLE_LIMIT    = 1_000_000;

   typedef enum {FLAW_NONE, FLAW_HEADER, FLAW_LENGTH, FLAW_CHECKSUM} frame_flaw_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       push = 1'b0;
   logic       full;
   logic       req_type = sfc_pkg::REQ_BYTE;
   logic [7:0] req_rx_byte = 8'h00;
   logic       empty;
   logic       pop = 1'b0;
   logic [2:0] rsp_status;
   logic [6:0] rsp_frame_length;
   logic       csr_we = 1'b0;
   logic       csr_index = sfc_pkg::CSR_START_FIRST;
   logic [7:0] csr_wdata = 8'h00;

   // Frame state mirror
   logic [7:0]  cfg_first = 8'h00;
   logic [7:0]  cfg_second = 8'h00;
   int          fr_count = 0;
   int          fr_polled = 0;
   logic [7:0]  fr_hdr1 = 8'h00;
   logic [7:0]  fr_hdr2 = 8'h00;
   logic [7:0]  fr_len = 8'h00;
   logic [7:0]  fr_new = 8'h00;
   logic [7:0]  fr_old = 8'h00;
   logic [15:0] fr_sum = 16'h0000;

   sfc_pkg::rsp_item_type poll_answer_q[$];

   int  items_sent = 0;
   int  results_checked = 0;
   int  mismatch_count = 0;
   int  cycle_count = 0;
   int  status_tally[6] = '{default: 0};
   int  rsp_hold_cycles = 0;
   bit  no_gaps = 1'b0;

   serial_frame_checker u_top (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_type        (req_type),
      .req_rx_byte     (req_rx_byte),
      .empty           (empty),
      .pop             (pop),
      .rsp_status      (rsp_status),
      .rsp_frame_length(rsp_frame_length),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #6 clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still pending",
                  cycle_count, poll_answer_q.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void record_mismatch(string msg);
      if (mismatch_count < 10)
         $display("%0t: mismatch, %s", $time, msg);
      mismatch_count++;
   endfunction

   // ---------------------------------------------------------------
   // Frame state mirror
   // ---------------------------------------------------------------
   function automatic void frame_clear();
      fr_count  = 0;
      fr_polled = 0;
      fr_hdr1   = 8'h00;
      fr_hdr2   = 8'h00;
      fr_len    = 8'h00;
      fr_new    = 8'h00;
      fr_old    = 8'h00;
      fr_sum    = 16'h0000;
   endfunction

   function automatic void frame_take_byte(logic [7:0] b);
      // full store drops the byte
      if (fr_count >= BUF_DEPTH) return;
      if (fr_count == HDR_FIRST_POS) fr_hdr1 = b;
      if (fr_count == HDR_SECOND_POS) fr_hdr2 = b;
      if (fr_count == LEN_FIELD_POS) fr_len = b;
      // sum trails the newest two bytes
      if (fr_count >= CK_BYTES) fr_sum = fr_sum + 16'(fr_old);
      fr_old = fr_new;
      fr_new = b;
      fr_count++;
   endfunction

   // Header, then length, then checksum
   function automatic void frame_verdict(output logic [2:0] st, output logic [6:0] len);
      int          n;
      logic [15:0] stored;
      n   = fr_count;
      len = '0;
      if (n <= HDR_FIRST_POS || n <= HDR_SECOND_POS)
         st = sfc_pkg::ST_HDR_ERR;
      else if (fr_hdr1 != cfg_first || fr_hdr2 != cfg_second)
         st = sfc_pkg::ST_HDR_ERR;
      else if (n >= BUF_DEPTH || n <= LEN_FIELD_POS)
         st = sfc_pkg::ST_LEN_ERR;
      else if (int'(fr_len) + CK_BYTES != n || n <= DATA_START_POS)
         st = sfc_pkg::ST_LEN_ERR;
      else begin
         stored = {fr_new, fr_old};
         if (stored != ~fr_sum)
            st = sfc_pkg::ST_CK_ERR;
         else begin
            st  = sfc_pkg::ST_OK;
            len = 7'(n);
         end
      end
   endfunction

   function automatic void frame_accept_item(logic kind, logic [7:0] data);
      sfc_pkg::rsp_item_type r;
      if (kind == sfc_pkg::REQ_BYTE) begin
         frame_take_byte(data);
         return;
      end
      r.frame_length = '0;
      if (fr_count == 0)
         r.status = sfc_pkg::ST_EMPTY;
      else if (fr_count != fr_polled) begin
         fr_polled = fr_count;
         r.status  = sfc_pkg::ST_RECEIVING;
      end else begin
         frame_verdict(r.status, r.frame_length);
         frame_clear();
      end
      poll_answer_q.push_back(r);
   endfunction

   // ---------------------------------------------------------------
   // Result side: pop with random stalls and optional long hold-off
   // ---------------------------------------------------------------
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            pop <= 1'b0;
            rsp_hold_cycles--;
         end else if (stall > 0) begin
            pop <= 1'b0;
            stall--;
         end else begin
            pop <= 1'b1;
            stall = no_gaps ? 0 : pick_gap();
         end
      end
   end

   // Compare each popped result with the oldest pending answer
   always @(posedge clock) begin : check_rsp
      sfc_pkg::rsp_item_type want;
      if (!reset && pop && !empty) begin
         results_checked++;
         if (poll_answer_q.size() == 0)
            record_mismatch($sformatf("unexpected result: status %0d length %0d",
                                      rsp_status, rsp_frame_length));
         else begin
            want = poll_answer_q.pop_front();
            if (want.status <= sfc_pkg::ST_CK_ERR) status_tally[want.status]++;
            if (rsp_status !== want.status)
               record_mismatch($sformatf("status: expected %0d, got %0d",
                                         want.status, rsp_status));
            if (rsp_frame_length !== want.frame_length)
               record_mismatch($sformatf("frame_length: expected %0d, got %0d",
                                         want.frame_length, rsp_frame_length));
         end
      end
   end

   // ---------------------------------------------------------------
   // Input side
   // ---------------------------------------------------------------
   task automatic send_item(input logic kind, input logic [7:0] data);
      int gap;
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push        <= 1'b1;
      req_type    <= kind;
      req_rx_byte <= data;
      @(posedge clock);
      while (full) @(posedge clock);
      frame_accept_item(kind, data);
      items_sent++;
   endtask

   task automatic send_poll();
      send_item(sfc_pkg::REQ_POLL, 8'($urandom_range(0, 255)));
   endtask

   // Stop offering items until every answer has come back
   task automatic wait_idle();
      push <= 1'b0;
      while (poll_answer_q.size() != 0) @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);
   endtask

   task automatic write_start_bytes(input logic [7:0] first, input logic [7:0] second);
      csr_we    <= 1'b1;
      csr_index <= sfc_pkg::CSR_START_FIRST;
      csr_wdata <= first;
      @(posedge clock);
      csr_index <= sfc_pkg::CSR_START_SECOND;
      csr_wdata <= second;
      @(posedge clock);
      csr_we     <= 1'b0;
      cfg_first  = first;
      cfg_second = second;
   endtask

   // Build a frame of n bytes with an optional flaw, then close it with polls if close is set
   task automatic send_frame(input int n, input frame_flaw_type flaw,
                             input int mid_poll_pct, input bit close);
      logic [7:0]  b [0:255];
      logic [15:0] sum;
      int          i;
      int          pos;
      b[0] = cfg_first;
      b[1] = cfg_second;
      b[2] = 8'(n - CK_BYTES);
      for (i = 3; i < n; i++) b[i] = 8'($urandom_range(0, 255));
      if (flaw == FLAW_LENGTH) b[2] = b[2] + 8'($urandom_range(1, 255));
      if (flaw == FLAW_HEADER) begin
         pos    = $urandom_range(0, 1);
         b[pos] = b[pos] ^ 8'(1 << $urandom_range(0, 7));
      end
      sum = '0;
      for (i = 0; i < n - CK_BYTES; i++) sum = sum + 16'(b[i]);
      // checksum stored low byte first
      b[n-2] = ~sum[7:0];
      b[n-1] = ~sum[15:8];
      if (flaw == FLAW_CHECKSUM) begin
         pos    = n - 1 - $urandom_range(0, 1);
         b[pos] = b[pos] ^ 8'(1 << $urandom_range(0, 7));
      end
      for (i = 0; i < n; i++) begin
         send_item(sfc_pkg::REQ_BYTE, b[i]);
         if (i < n - 1 && $urandom_range(0, 99) < mid_poll_pct) send_poll();
      end
      if (close) begin
         send_poll();
         send_poll();
         if ($urandom_range(0, 9) == 0) send_poll();
      end
   endtask

   // Random bytes and polls with no frame structure
   task automatic send_noise();
      int k;
      k = $urandom_range(1, 6);
      repeat (k) begin
         if ($urandom_range(0, 99) < 30)
            send_poll();
         else
            send_item(sfc_pkg::REQ_BYTE, 8'($urandom_range(0, 255)));
      end
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   task automatic test_directed();
      write_start_bytes(8'h00, 8'hFF);
      // poll on an empty store
      send_poll();
      // second header byte never arrived
      send_item(sfc_pkg::REQ_BYTE, 8'h00);
      send_poll();
      send_poll();
      // length byte never arrived
      send_item(sfc_pkg::REQ_BYTE, 8'h00);
      send_item(sfc_pkg::REQ_BYTE, 8'hFF);
      send_poll();
      send_poll();
      // shortest good frame, then one with a bad checksum
      send_frame(5, FLAW_NONE, 0, 1'b1);
      send_frame(5, FLAW_CHECKSUM, 0, 1'b1);
   endtask

   // Longest good frame, a full store, and bytes dropped past the full store
   task automatic test_long_frames();
      send_frame(BUF_DEPTH - 1, FLAW_NONE, 0, 1'b1);
      send_frame(BUF_DEPTH, FLAW_NONE, 0, 1'b1);
      send_frame(BUF_DEPTH + 3, FLAW_NONE, 5, 1'b1);
   endtask

   // Receiver holds off while polls keep coming, so the input stalls
   task automatic test_result_stall();
      wait_idle();
      rsp_hold_cycles = 300;
      repeat (40) begin
         if ($urandom_range(0, 99) < 75)
            send_poll();
         else
            send_item(sfc_pkg::REQ_BYTE, 8'($urandom_range(0, 255)));
      end
      wait_idle();
   endtask

   task automatic test_random_frames(input logic [7:0] first, input logic [7:0] second,
                                     input bit gapless);
      int             start;
      int             r;
      int             n;
      frame_flaw_type flaw;
      wait_idle();
      write_start_bytes(first, second);
      no_gaps = gapless;
      start   = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
         r = $urandom_range(0, 99);
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 60) : $urandom_range(4, 20);
         if (r < 8)
            flaw = FLAW_HEADER;
         else if (r < 15)
            flaw = FLAW_LENGTH;
         else if (r < 23)
            flaw = FLAW_CHECKSUM;
         else
            flaw = FLAW_NONE;
         if (r >= 93)
            send_noise();
         else
            send_frame(n, flaw, 10, $urandom_range(0, 19) != 0);
      end
      no_gaps = 1'b0;
   endtask

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_long_frames();
      test_result_stall();
      test_random_frames(8'hFF, 8'h00, 1'b0);
      test_random_frames(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);
      test_random_frames(8'h00, 8'h00, 1'b1);
      test_random_frames(8'hFF, 8'hFF, 1'b0);
      test_random_frames(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);
      test_random_frames(8'h5A, 8'hA5, 1'b1);
      wait_idle();

      mismatch_count += poll_answer_q.size();
      $display("Sent %0d items, checked %0d results over seven start-byte settings",
               items_sent, results_checked);
      $display("Status tally: empty %0d receiving %0d ok %0d header %0d length %0d cksum %0d",
               status_tally[sfc_pkg::ST_EMPTY], status_tally[sfc_pkg::ST_RECEIVING],
               status_tally[sfc_pkg::ST_OK], status_tally[sfc_pkg::ST_HDR_ERR],
               status_tally[sfc_pkg::ST_LEN_ERR], status_tally[sfc_pkg::ST_CK_ERR]);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
